// ----- design/sib_pkg.sv -----
// Package for the sorted insertion buffer.
// Holds the word field widths, the status codes and the default depth.
// Used by sib_cell and sorted_insertion_buffer; depends on nothing.
package sib_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;
    localparam int STATUS_W      = 2;
    localparam int FILL_W        = 5;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ELEMENT  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    typedef logic signed [DATA_W-1:0] data_t;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic rotate;
    } cell_ctl_t;

endpackage

// ----- design/sib_cell.sv -----
// One storage cell of the sorted chain: one entry plus its compare logic.
// Depends on sib_pkg for the data and control types.
module sib_cell (
    input  logic              clk,
    input  sib_pkg::cell_ctl_t ctl,
    input  logic              occupied,
    input  sib_pkg::data_t    ins_value,
    input  logic              left_ge,
    input  sib_pkg::data_t    left_entry,
    input  sib_pkg::data_t    right_entry,
    output logic              ge,
    output sib_pkg::data_t    entry
);
    import sib_pkg::*;

    data_t entry_reg;
    data_t entry_next;

    // An empty cell behaves as if it held a value above every input.
    assign ge    = !occupied || (entry_reg >= ins_value);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.insert && ge)
        begin
            // The first cell at or above the new value takes it; the ones
            // after it take the entry of their left neighbor.
            entry_next = left_ge ? left_entry : ins_value;
        end
        else if (ctl.rotate)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ----- design/sorted_insertion_buffer.sv -----
// Sorted insertion buffer: a chain of DEPTH cells kept in ascending order.
// Depends on sib_pkg and sib_cell.
//
// An insert is accepted without raising busy, so inserts may follow
// each other in every cycle; its status word appears in the cycle after start.
// A dump of a non-empty buffer rotates the chain toward cell 0 once around,
// holding busy high all that time; as each element reaches cell 0 its word
// goes out on the result ports, registered after busy_reg rises, and after
// the full rotation the contents are back in place. A dump of an empty
// buffer answers with one word and does not raise busy. The receiver cannot
// stall: each word is valid for the single cycle in which strobe is high.
module sorted_insertion_buffer #(
    parameter int DEPTH = sib_pkg::DEPTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           cmd,
    input  logic signed [sib_pkg::DATA_W-1:0] value,
    output logic                           strobe,
    output logic [sib_pkg::STATUS_W-1:0]   status,
    output logic signed [sib_pkg::DATA_W-1:0] item,
    output logic [sib_pkg::FILL_W-1:0]     fill,
    output logic                           is_last
);
    import sib_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    logic [CW-1:0]       count_reg, count_next;
    logic [IW-1:0]       step_reg, step_next;
    logic                busy_reg, busy_next;
    logic                strobe_reg, strobe_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    data_t               item_reg, item_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic                last_reg, last_next;

    cell_ctl_t           ctl;
    logic [DEPTH-1:0]    ge;
    data_t               entry [DEPTH];
    logic                accept;
    logic                full;
    logic [31:0]         count_wide;
    logic [31:0]         count_inc_wide;

    assign accept         = start && !busy_reg;
    assign full           = (count_reg == CW'(DEPTH));
    assign count_wide     = 32'(count_reg);
    assign count_inc_wide = 32'(count_reg + CW'(1));

    assign ctl.insert = accept && !cmd && !full;
    assign ctl.rotate = busy_reg;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            sib_cell u_cell (
                .clk         (clk),
                .ctl         (ctl),
                .occupied    (CW'(g) < count_reg),
                .ins_value   (value),
                .left_ge     ((g == 0) ? 1'b0 : ge[(g == 0) ? 0 : g - 1]),
                .left_entry  ((g == 0) ? value : entry[(g == 0) ? 0 : g - 1]),
                .right_entry (entry[(g + 1) % DEPTH]),
                .ge          (ge[g]),
                .entry       (entry[g])
            );
        end
    endgenerate

    always_comb
    begin
        count_next  = count_reg;
        step_next   = step_reg;
        busy_next   = busy_reg;
        strobe_next = 1'b0;
        status_next = status_reg;
        item_next   = item_reg;
        fill_next   = fill_reg;
        last_next   = last_reg;

        if (busy_reg)
        begin
            // Cell 0 holds the element of this step of the rotation.
            if (CW'(step_reg) < count_reg)
            begin
                strobe_next = 1'b1;
                status_next = ST_ELEMENT;
                item_next   = entry[0];
                fill_next   = count_wide[FILL_W-1:0];
                last_next   = (CW'(step_reg) == count_reg - CW'(1));
            end
            if (step_reg == IW'(DEPTH - 1))
            begin
                busy_next = 1'b0;
                step_next = '0;
            end
            else
            begin
                step_next = step_reg + IW'(1);
            end
        end
        else if (accept)
        begin
            item_next = '0;
            last_next = 1'b1;
            if (!cmd)
            begin
                strobe_next = 1'b1;
                if (full)
                begin
                    status_next = ST_FULL;
                    fill_next   = count_wide[FILL_W-1:0];
                end
                else
                begin
                    status_next = ST_INSERTED;
                    fill_next   = count_inc_wide[FILL_W-1:0];
                    count_next  = count_reg + CW'(1);
                end
            end
            else if (count_reg == '0)
            begin
                strobe_next = 1'b1;
                status_next = ST_EMPTY;
                fill_next   = '0;
            end
            else
            begin
                busy_next = 1'b1;
                step_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            step_reg   <= '0;
            busy_reg   <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            step_reg   <= step_next;
            busy_reg   <= busy_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        item_reg   <= item_next;
        fill_reg   <= fill_next;
        last_reg   <= last_next;
    end

    assign busy    = busy_reg;
    assign strobe  = strobe_reg;
    assign status  = status_reg;
    assign item    = item_reg;
    assign fill    = fill_reg;
    assign is_last = last_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fill count above depth");

    a_dump_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd && count_reg != '0) |=> busy_reg ##1 strobe_reg)
        else $error("dump of a non-empty buffer did not start");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |=> $stable(count_reg))
        else $error("fill count changed during a dump");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && status_reg == ST_FULL) |-> (count_reg == CW'(DEPTH)))
        else $error("full status while not full");
`endif

endmodule
